@@ hw/rtl/lis_pkg.sv @@
// Shared types and constants for the LIS length tracker.
// No dependencies; used by every file under hw/rtl.
package lis_pkg;

  localparam int LIS_MAX_TAILS  = 256;  // default tail store depth
  localparam int LIS_VALUE_BITS = 32;   // default element width

  localparam int LEN_W      = 9;        // length field width
  localparam int LEN_MAX    = 511;      // length field saturation value
  localparam int OUT_DATA_W = ((LEN_W + 7) / 8) * 8;

  // front-to-back queue
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic first;  // clear the tail store before this element
    logic last;   // final element of the sequence
  } lis_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_UPDATE,
    ST_EMIT
  } lis_state_t;

endpackage

@@ hw/rtl/lis_front.sv @@
// Input side: takes stream transactions, splits out the key and the control
// flags, and holds them in a short queue for the back end. Uses lis_pkg.
module lis_front #(
  parameter int VALUE_BITS = lis_pkg::LIS_VALUE_BITS,
  parameter int IN_DATA_W  = ((VALUE_BITS + 7) / 8) * 8
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_tvalid,
  output logic                    in_tready,
  input  logic [IN_DATA_W-1:0]    in_tdata,
  input  logic                    in_tuser,
  input  logic                    in_tlast,
  output logic                    deq_valid,
  input  logic                    deq_ready,
  output logic [VALUE_BITS-1:0]   deq_key,
  output lis_pkg::lis_ctl_t       deq_ctl
);

  logic [VALUE_BITS-1:0]         q_key_r [lis_pkg::QDEPTH];
  lis_pkg::lis_ctl_t             q_ctl_r [lis_pkg::QDEPTH];
  logic [lis_pkg::QPTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [lis_pkg::QPTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [lis_pkg::QCNT_W-1:0]    fill_r, fill_nxt;
  logic                          push, pop;
  lis_pkg::lis_ctl_t             in_ctl;

  assign in_tready = (fill_r != lis_pkg::QCNT_W'(lis_pkg::QDEPTH));
  assign deq_valid = (fill_r != '0);
  assign push      = in_tvalid & in_tready;
  assign pop       = deq_valid & deq_ready;

  // classify: low VALUE_BITS of tdata are the element, tuser is the clear flag
  assign in_ctl.first = in_tuser;
  assign in_ctl.last  = in_tlast;

  assign deq_key = q_key_r[rd_ptr_r];
  assign deq_ctl = q_ctl_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == lis_pkg::QPTR_W'(lis_pkg::QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == lis_pkg::QPTR_W'(lis_pkg::QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (pop && !push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_key_r[wr_ptr_r] <= in_tdata[VALUE_BITS-1:0];
      q_ctl_r[wr_ptr_r] <= in_ctl;
    end
  end

endmodule

@@ hw/rtl/lis_back.sv @@
// Back end: binary lower-bound search over the sorted tail memory, one probe
// per cycle, then replace/append and the registered result. Uses lis_pkg.
module lis_back #(
  parameter int MAX_TAILS  = lis_pkg::LIS_MAX_TAILS,
  parameter int VALUE_BITS = lis_pkg::LIS_VALUE_BITS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           deq_valid,
  output logic                           deq_ready,
  input  logic [VALUE_BITS-1:0]          deq_key,
  input  lis_pkg::lis_ctl_t              deq_ctl,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [lis_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                           out_tuser,
  output logic                           out_tlast
);

  localparam int AW    = $clog2(MAX_TAILS);
  localparam int CNT_W = $clog2(MAX_TAILS + 1);
  localparam int EXT_W = (CNT_W > lis_pkg::LEN_W) ? CNT_W : lis_pkg::LEN_W;

  logic signed [VALUE_BITS-1:0] mem [MAX_TAILS];
  logic signed [VALUE_BITS-1:0] rd_data_r;
  logic signed [VALUE_BITS-1:0] key_r, key_nxt;

  lis_pkg::lis_state_t state_r, state_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                ovf_r, ovf_nxt;
  logic                last_r, last_nxt;
  logic [CNT_W-1:0]    lo_r, lo_nxt;
  logic [CNT_W-1:0]    hi_r, hi_nxt;
  logic [AW-1:0]       mid_r, mid_nxt;

  logic                out_tvalid_r, out_tvalid_nxt;
  logic [lis_pkg::LEN_W-1:0] out_len_r;
  logic                out_last_r, out_ovf_r;
  logic                out_load;

  // search datapath
  logic [CNT_W-1:0] cnt_start;
  logic             probe_ge;
  logic [CNT_W-1:0] lo_c, hi_c;
  logic [CNT_W:0]   sum_c;
  logic [AW-1:0]    mid_c;
  logic             search_more;
  logic             hit;
  logic             rd_en, wr_en;
  logic [AW-1:0]    wr_addr;
  logic [EXT_W-1:0] cnt_ext;
  logic [lis_pkg::LEN_W-1:0] len_sat;

  assign cnt_start = deq_ctl.first ? '0 : cnt_r;
  assign probe_ge  = (rd_data_r >= key_r);

  always_comb begin
    if (state_r == lis_pkg::ST_IDLE) begin
      lo_c = '0;
      hi_c = cnt_start;
    end else if (probe_ge) begin
      lo_c = lo_r;
      hi_c = CNT_W'(mid_r);
    end else begin
      lo_c = CNT_W'(mid_r) + 1'b1;
      hi_c = hi_r;
    end
  end

  assign sum_c       = {1'b0, lo_c} + {1'b0, hi_c};
  assign mid_c       = sum_c[AW:1];
  assign search_more = (lo_c < hi_c);
  assign hit         = (lo_r < cnt_r);
  assign wr_addr     = hit ? lo_r[AW-1:0] : cnt_r[AW-1:0];

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lis_pkg::ST_IDLE: begin
        if (deq_valid) begin
          state_nxt = search_more ? lis_pkg::ST_SEARCH : lis_pkg::ST_UPDATE;
        end
      end
      lis_pkg::ST_SEARCH: begin
        if (!search_more) state_nxt = lis_pkg::ST_UPDATE;
      end
      lis_pkg::ST_UPDATE: state_nxt = lis_pkg::ST_EMIT;
      lis_pkg::ST_EMIT: begin
        if (!out_tvalid_r || out_tready) state_nxt = lis_pkg::ST_IDLE;
      end
      default: state_nxt = lis_pkg::ST_IDLE;
    endcase
  end

  // outputs and datapath controls
  always_comb begin
    deq_ready = 1'b0;
    rd_en     = 1'b0;
    wr_en     = 1'b0;
    out_load  = 1'b0;
    key_nxt   = key_r;
    last_nxt  = last_r;
    cnt_nxt   = cnt_r;
    ovf_nxt   = ovf_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    mid_nxt   = mid_r;
    unique case (state_r)
      lis_pkg::ST_IDLE: begin
        deq_ready = 1'b1;
        if (deq_valid) begin
          key_nxt  = deq_key;
          last_nxt = deq_ctl.last;
          cnt_nxt  = cnt_start;
          ovf_nxt  = ovf_r & ~deq_ctl.first;
          lo_nxt   = lo_c;
          hi_nxt   = hi_c;
          mid_nxt  = mid_c;
          rd_en    = search_more;
        end
      end
      lis_pkg::ST_SEARCH: begin
        lo_nxt  = lo_c;
        hi_nxt  = hi_c;
        mid_nxt = mid_c;
        rd_en   = search_more;
      end
      lis_pkg::ST_UPDATE: begin
        if (hit) begin
          wr_en = 1'b1;
        end else if (cnt_r != CNT_W'(MAX_TAILS)) begin
          wr_en   = 1'b1;
          cnt_nxt = cnt_r + 1'b1;
        end else begin
          ovf_nxt = 1'b1;
        end
      end
      lis_pkg::ST_EMIT: begin
        out_load = !out_tvalid_r || out_tready;
      end
      default: ;
    endcase
  end

  // length field saturates if the store is deeper than the field
  assign cnt_ext = EXT_W'(cnt_r);
  assign len_sat = (cnt_ext > EXT_W'(lis_pkg::LEN_MAX)) ?
                   lis_pkg::LEN_W'(lis_pkg::LEN_MAX) : cnt_ext[lis_pkg::LEN_W-1:0];

  assign out_tvalid_nxt = out_load | (out_tvalid_r & ~out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= lis_pkg::ST_IDLE;
      cnt_r        <= '0;
      ovf_r        <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      ovf_r        <= ovf_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r  <= key_nxt;
    last_r <= last_nxt;
    lo_r   <= lo_nxt;
    hi_r   <= hi_nxt;
    mid_r  <= mid_nxt;
    if (out_load) begin
      out_len_r  <= len_sat;
      out_last_r <= last_r;
      out_ovf_r  <= ovf_r;
    end
  end

  // tail memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= key_r;
    if (rd_en) rd_data_r <= mem[mid_c];
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = lis_pkg::OUT_DATA_W'(out_len_r);
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_ovf_r;

endmodule

@@ hw/rtl/lis_length_tracker.sv @@
// Top level of the LIS length tracker: input front end, queue, search back end.
// Depends on lis_pkg, lis_front and lis_back.
//
// Streams signed elements in and returns, for every element, the length of the
// longest strictly increasing subsequence seen since the last clear
// (patience sorting). The tails of the runs sit sorted in a MAX_TAILS-deep
// memory; each element does a binary lower-bound search in it, one memory
// probe per cycle, then replaces the tail found or appends. The back end
// takes one element at a time and its search loop runs through the single
// read port. A four-entry queue lets the input side keep accepting while
// the back end searches, and the result register lets a finished result wait
// for the sink without stopping the search of the next element. in_tuser set
// clears the store before its element; out_tuser reports an append dropped
// because the store was full (sticky until the next clear); out_tlast echoes
// in_tlast. The tail memory needs no clearing after reset.
module lis_length_tracker #(
  parameter int MAX_TAILS  = lis_pkg::LIS_MAX_TAILS,
  parameter int VALUE_BITS = lis_pkg::LIS_VALUE_BITS,
  parameter int IN_DATA_W  = ((VALUE_BITS + 7) / 8) * 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // input channel
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [IN_DATA_W-1:0]           in_tdata,   // [VALUE_BITS-1:0] value, zero pad above
  input  logic                           in_tuser,   // [0] first
  input  logic                           in_tlast,   // last
  // result channel
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [lis_pkg::OUT_DATA_W-1:0] out_tdata,  // [8:0] length, zero pad above
  output logic                           out_tuser,  // [0] overflow
  output logic                           out_tlast   // final_res
);

  logic                    deq_valid;
  logic                    deq_ready;
  logic [VALUE_BITS-1:0]   deq_key;
  lis_pkg::lis_ctl_t       deq_ctl;

  lis_front #(
    .VALUE_BITS (VALUE_BITS),
    .IN_DATA_W  (IN_DATA_W)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .deq_valid (deq_valid),
    .deq_ready (deq_ready),
    .deq_key   (deq_key),
    .deq_ctl   (deq_ctl)
  );

  lis_back #(
    .MAX_TAILS  (MAX_TAILS),
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .deq_valid  (deq_valid),
    .deq_ready  (deq_ready),
    .deq_key    (deq_key),
    .deq_ctl    (deq_ctl),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  localparam int LEN_TOP = (MAX_TAILS > lis_pkg::LEN_MAX) ? lis_pkg::LEN_MAX : MAX_TAILS;

  // back end works on one element at a time: a pop leaves it busy
  assert property (@(posedge clk) disable iff (!rst_n)
    deq_valid && deq_ready |=> !deq_ready)
    else $error("back end took a second element while busy");

  // queue full implies something to hand over
  assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> deq_valid)
    else $error("queue reports full and empty at once");

  // reported length never exceeds the store depth
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[lis_pkg::LEN_W-1:0] <= lis_pkg::LEN_W'(LEN_TOP)))
    else $error("length beyond store depth");

  // a dropped append only happens with the store full
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> (out_tdata[lis_pkg::LEN_W-1:0] == lis_pkg::LEN_W'(LEN_TOP)))
    else $error("overflow flagged with store not full");

endmodule

@@ sim/lis_length_tracker_tb.sv @@
// Self-checking bench for lis_length_tracker: directed cases and random bursty streams with a scoreboard.
// Depends on lis_pkg and lis_length_tracker; uses nothing outside the RTL.
module lis_length_tracker_tb;

  localparam int VAL_W       = lis_pkg::LIS_VALUE_BITS;
  localparam int TARGET      = 650;     // approximate number of elements in the run
  localparam int CYCLE_LIMIT = 300000;  // several times the slowest legal run
  localparam int DRAIN_WAIT  = 40;      // > one element's worst search latency
  localparam int HOLD_AFTER  = 120;     // results seen before the long sink stall
  localparam int HOLD_LEN    = 600;     // cycles of the long sink stall

  // One input element as the driver sees it.
  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    lis_pkg::lis_ctl_t       ctl;
  } lis_element_t;

  // One result as the scoreboard sees it.
  typedef struct packed {
    logic [lis_pkg::LEN_W-1:0] length;
    logic                      final_res;
    logic                      overflow;
  } lis_result_t;

  // Shapes of generated sequences.
  typedef enum int {
    RUN_NOISE,    // full-range random values
    RUN_NARROW,   // tiny range, lots of duplicates
    RUN_RISING,   // mostly rising with small dips
    RUN_FALLING,  // mostly falling
    RUN_FILL      // long rising run that fills the tail store
  } run_shape_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [VAL_W-1:0] in_tdata  = '0;  // [31:0] value
  logic             in_tuser  = 1'b0;  // [0] first
  logic             in_tlast  = 1'b0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [lis_pkg::OUT_DATA_W-1:0] out_tdata;  // [8:0] length, pad above
  logic             out_tuser;       // [0] overflow
  logic             out_tlast;       // final_res

  lis_length_tracker uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always #10 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Patience-sorting predictor. run_tails[0..tail_count-1] is kept sorted
  // ascending; entries at or above tail_count are never read.
  // ---------------------------------------------------------------------------
  logic signed [VAL_W-1:0] run_tails [lis_pkg::LIS_MAX_TAILS];
  int unsigned             tail_count   = 0;
  bit                      store_dropped = 1'b0;

  function automatic lis_result_t advance_lis(lis_element_t e);
    lis_result_t r;
    int unsigned slot;
    if (e.ctl.first) begin
      tail_count    = 0;
      store_dropped = 1'b0;
    end
    // lower bound: first tail not less than the new value
    slot = tail_count;
    for (int unsigned i = 0; i < tail_count; i++) begin
      if (run_tails[i] >= e.value) begin
        slot = i;
        break;
      end
    end
    if (slot < tail_count) begin
      run_tails[slot] = e.value;
    end else if (tail_count < lis_pkg::LIS_MAX_TAILS) begin
      run_tails[tail_count] = e.value;
      tail_count++;
    end else begin
      store_dropped = 1'b1;  // append lost, sticky until next clear
    end
    r.length    = (tail_count > lis_pkg::LEN_MAX) ? lis_pkg::LEN_W'(lis_pkg::LEN_MAX) :
                                                    lis_pkg::LEN_W'(tail_count);
    r.final_res = e.ctl.last;
    r.overflow  = store_dropped;
    return r;
  endfunction

  lis_element_t elements_to_send[$];
  lis_result_t  expected_lengths[$];

  int mismatches   = 0;
  int results_seen = 0;

  task automatic queue_element(logic signed [VAL_W-1:0] v, logic f, logic l);
    lis_element_t e;
    e.value     = v;
    e.ctl.first = f;
    e.ctl.last  = l;
    elements_to_send.insert(elements_to_send.size(), e);
  endtask

  // Append one generated sequence. Most sequences open with a clear; a few
  // continue the previous one, and stray first/last flags break some up.
  task automatic add_run(int n, run_shape_t shape);
    logic signed [VAL_W-1:0] v;
    logic signed [VAL_W-1:0] lvl;
    logic                    f;
    logic                    l;
    if (shape == RUN_FILL) begin
      lvl = -32'sd2000000000 + $urandom_range(0, 100);
    end else begin
      lvl = $urandom_range(0, 2000) - 1000;
    end
    for (int i = 0; i < n; i++) begin
      case (shape)
        RUN_NOISE: begin
          v = $urandom();
        end
        RUN_NARROW: begin
          v = $urandom_range(0, 16) - 8;
        end
        RUN_RISING: begin
          if ($urandom_range(0, 5) == 0) begin
            v = lvl - $urandom_range(0, 20);
          end else begin
            lvl = lvl + $urandom_range(0, 3);
            v   = lvl;
          end
        end
        RUN_FALLING: begin
          if ($urandom_range(0, 7) == 0) begin
            v = lvl + $urandom_range(1, 20);
          end else begin
            lvl = lvl - $urandom_range(0, 3);
            v   = lvl;
          end
        end
        default: begin
          // every rising step tops the store; dips replace inside it
          if ($urandom_range(0, 7) == 0) begin
            v = lvl - $urandom_range(1, 50000);
          end else begin
            lvl = lvl + $urandom_range(1, 4000);
            v   = lvl;
          end
        end
      endcase
      if (i == 0) begin
        f = (shape == RUN_FILL) ? 1'b1 : ($urandom_range(0, 6) != 0);
      end else begin
        f = (shape != RUN_FILL) && ($urandom_range(0, 39) == 0);
      end
      l = (i == n - 1) || ($urandom_range(0, 15) == 0);
      queue_element(v, f, l);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: bursts of random length separated by random gaps. A gap of zero
  // merges bursts, which gives back-to-back stretches. The prediction runs on
  // each accepted transaction, so expectations stay in acceptance order.
  // ---------------------------------------------------------------------------
  int burst_left = 1;
  int gap_left   = 0;

  always @(posedge clk) begin
    logic holding;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      holding = in_tvalid;
      if (in_tvalid && in_tready) begin
        expected_lengths.insert(expected_lengths.size(), advance_lis(elements_to_send[0]));
        void'(elements_to_send.pop_front());
        holding = 1'b0;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
      if (holding) begin
        // valid stays up with the same payload until accepted
      end else if (gap_left > 0) begin
        gap_left--;
        in_tvalid <= 1'b0;
      end else if (elements_to_send.size() > 0) begin
        in_tvalid <= 1'b1;
        in_tdata  <= elements_to_send[0].value;
        in_tuser  <= elements_to_send[0].ctl.first;
        in_tlast  <= elements_to_send[0].ctl.last;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sink: cycles through four ready patterns (always ready, 50%, 25%, 75%).
  // Once, after HOLD_AFTER results, it holds ready low for the long stall that HOLD_LEN sets, so
  // the internal queue fills and in_tready has to drop.
  // ---------------------------------------------------------------------------
  int rx_cycle  = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      rx_cycle++;
      if (!hold_done && results_seen >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        case ((rx_cycle / 128) % 4)
          0:       out_tready <= 1'b1;
          1:       out_tready <= ($urandom_range(0, 1) == 0);
          2:       out_tready <= ($urandom_range(0, 3) == 0);
          default: out_tready <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor / scoreboard: each accepted result transaction against the oldest
  // expectation, field by field.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    lis_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (expected_lengths.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("[%0t] unexpected result: length=%0d last=%0b ovf=%0b",
                   $realtime, out_tdata[lis_pkg::LEN_W-1:0], out_tlast, out_tuser);
        end
      end else begin
        want = expected_lengths.pop_front();
        if (out_tdata[lis_pkg::LEN_W-1:0] !== want.length || out_tlast !== want.final_res ||
            out_tuser !== want.overflow) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("[%0t] result %0d: exp len=%0d last=%0b ovf=%0b, got %0d/%0b/%0b",
                     $realtime, results_seen, want.length, want.final_res, want.overflow,
                     out_tdata[lis_pkg::LEN_W-1:0], out_tlast, out_tuser);
          end
        end
      end
    end
  end

  // Watchdog
  int cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of test.
  // ---------------------------------------------------------------------------
  initial begin
    bit fill_done;
    fill_done = 1'b0;

    // Directed: elements before any clear continue from the reset state
    queue_element(32'sd5, 1'b0, 1'b0);
    queue_element(32'sd3, 1'b0, 1'b0);
    queue_element(32'sd9, 1'b0, 1'b1);
    queue_element(32'sd9, 1'b0, 1'b0);   // store survives a last flag
    // value extremes and equal values (equal replaces, never appends)
    queue_element(32'sh8000_0000, 1'b1, 1'b0);
    queue_element(32'sh7FFF_FFFF, 1'b0, 1'b0);
    queue_element(32'sh7FFF_FFFF, 1'b0, 1'b0);
    queue_element(32'sd0, 1'b0, 1'b0);
    queue_element(-32'sd1, 1'b0, 1'b0);
    queue_element(32'sh8000_0000, 1'b0, 1'b1);
    // one-element sequence
    queue_element(32'sd42, 1'b1, 1'b1);
    // strictly falling: length stays at one
    queue_element(32'sd100, 1'b1, 1'b0);
    queue_element(32'sd50, 1'b0, 1'b0);
    queue_element(32'sd0, 1'b0, 1'b0);
    queue_element(-32'sd50, 1'b0, 1'b0);
    queue_element(-32'sd100, 1'b0, 1'b1);
    // strictly rising across zero
    for (int i = -3; i <= 2; i++) begin
      queue_element(i, (i == -3), (i == 2));
    end
    // alternating bit patterns
    queue_element(32'sh5555_5555, 1'b1, 1'b0);
    queue_element(32'shAAAA_AAAA, 1'b0, 1'b1);

    // Random sequences; one long run drives the store to full, then keeps
    // replacing and rising past it, so dropped appends raise the overflow flag.
    while (elements_to_send.size() < TARGET) begin
      if (!fill_done && elements_to_send.size() > 200) begin
        add_run(330, RUN_FILL);
        fill_done = 1'b1;
      end else begin
        add_run($urandom_range(1, 30), run_shape_t'($urandom_range(0, 3)));
      end
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while (elements_to_send.size() > 0 || expected_lengths.size() > 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_WAIT) @(posedge clk);

    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/lis_pkg.sv
hw/rtl/lis_front.sv
hw/rtl/lis_back.sv
hw/rtl/lis_length_tracker.sv
sim/lis_length_tracker_tb.sv
